### hw/rtl/stg_pkg.sv
// Shared constants, types and the quarter-wave sine table builder for the tone generator.
package stg_pkg;

	localparam int PHASE_BITS      = 32;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int COUNT_BITS      = 24;

	localparam int TUNING_BITS = 32;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS = 1;
	localparam int FRAME_COUNT_BITS = 24;
	localparam int SAMPLE_BITS = 16;

	localparam int TABLE_N   = 1 << TABLE_ADDR_BITS;
	localparam int ROM_ADDR_BITS = TABLE_ADDR_BITS + 1;

	localparam int MAG_BITS  = 15;
	localparam int PCT_BITS  = 7;
	localparam int PROD_BITS = MAG_BITS + PCT_BITS;

	localparam logic [MAG_BITS-1:0] FULL_SCALE = MAG_BITS'(32767);
	localparam logic [PCT_BITS-1:0] PCT_MAX    = PCT_BITS'(100);
	localparam logic [PCT_BITS-1:0] PCT_RESET  = PCT_BITS'(50);

	// floor(p / 100) == (p * RECIP) >> DIV_SHIFT for every p below 2^PROD_BITS
	localparam int DIV_SHIFT  = PROD_BITS + 7;
	localparam longint RECIP_VAL = ((64'd1 << DIV_SHIFT) + 64'd99) / 64'd100;
	localparam int RECIP_BITS = DIV_SHIFT - 6;
	localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_VAL);

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [0:6] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TUNING    = 1'b0,
		REG_AMPLITUDE = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_FRAME = 1'b1
	} func_t;

	// per-sample side information traveling down the pipe
	typedef struct packed {
		logic neg;
		logic last;
	} tag_t;

	typedef logic [MAG_BITS-1:0] rom_t [0:TABLE_N];

	// Q30 Taylor series of sin(pi/2 * k / N), rounded to full scale
	function automatic logic [MAG_BITS-1:0] sine_entry(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] v;
		longint      sum;
		x    = (HALF_PI_Q30 * 64'(k)) / TABLE_N;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
			if ((n & 1) != 0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (64'(sum) * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
		if (v > 64'(FULL_SCALE)) begin
			v = 64'(FULL_SCALE);
		end
		return MAG_BITS'(v);
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k <= TABLE_N; k++) begin
			r[k] = sine_entry(k);
		end
		return r;
	endfunction

endpackage

### hw/rtl/stg_sine_rom.sv
// Quarter-wave sine ROM with registered read data.
module stg_sine_rom (
	input  logic                               clk,
	input  logic                               en,
	input  logic [stg_pkg::ROM_ADDR_BITS-1:0]  addr,
	output logic [stg_pkg::MAG_BITS-1:0]       data
);
	import stg_pkg::*;

	localparam rom_t ROM = build_rom();

	logic [MAG_BITS-1:0] data_q;

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= ROM[addr];
		end
	end

	assign data = data_q;

endmodule

### hw/rtl/stg_gain_pipe.sv
// Volume scaling pipeline: multiply by percent, divide by 100, apply sign, output register.
module stg_gain_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [stg_pkg::MAG_BITS-1:0]  mag,
	input  stg_pkg::tag_t                 tag,
	input  logic [stg_pkg::PCT_BITS-1:0]  pct,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [stg_pkg::SAMPLE_BITS-1:0] sample,
	output logic                          last
);
	import stg_pkg::*;

	logic                  v_s2, v_s3, v_q;
	logic [PROD_BITS-1:0]  prod_s2;
	logic [MAG_BITS-1:0]   quot_s3;
	tag_t                  tag_s2, tag_s3;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                  last_q;

	logic                  out_rdy, s3_rdy, s2_rdy;
	logic [PROD_BITS+RECIP_BITS-1:0] wide;
	logic [SAMPLE_BITS-1:0] mag_ext;

	assign out_rdy  = ~v_q | out_ready;
	assign s3_rdy   = ~v_s3 | out_rdy;
	assign s2_rdy   = ~v_s2 | s3_rdy;
	assign in_ready = s2_rdy;

	assign wide    = (PROD_BITS+RECIP_BITS)'(prod_s2) * (PROD_BITS+RECIP_BITS)'(RECIP);
	assign mag_ext = SAMPLE_BITS'(quot_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (s2_rdy) v_s2 <= in_valid;
			if (s3_rdy) v_s3 <= v_s2;
			if (out_rdy) v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_rdy && in_valid) begin
			prod_s2 <= PROD_BITS'(mag) * PROD_BITS'(pct);
			tag_s2  <= tag;
		end
		if (s3_rdy && v_s2) begin
			quot_s3 <= wide[DIV_SHIFT +: MAG_BITS];
			tag_s3  <= tag_s2;
		end
		if (out_rdy && v_s3) begin
			sample_q <= tag_s3.neg ? -$signed(mag_ext) : $signed(mag_ext);
			last_q   <= tag_s3.last;
		end
	end

	assign out_valid = v_q;
	assign sample    = sample_q;
	assign last      = last_q;

endmodule

### hw/rtl/sine_tone_generator.sv
// Top level of the fixed-length DDS sine tone generator.
//
//  port group  | dir | transfer when           | payload
//  ------------+-----+-------------------------+-------------------------------------
//  cfg_*       | in  | cfg_valid & cfg_ready   | cfg_index (0 tuning, 1 amplitude), cfg_data
//  in_*        | in  | in_valid & in_ready     | func, frame_count
//  out_*       | out | out_valid & out_ready   | left_sample, right_sample, last_frame
//
// One item per clock sustained while out_ready holds high. A frame request's sample
// passes these registers in order: ROM read registered at the transfer edge, then
// percent multiply, reciprocal multiply, output register.
// Start items and requests with no frames left update state only and make no sample.
// Reset clears phase, frame count, tuning word and pipe valids; amplitude resets to 50.
// Each stage holds when the one after it is full and stalled; empty stages keep
// filling, so input transfers continue while a finished sample waits on out_ready.
module sine_tone_generator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [stg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [stg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	// input items
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 func,
	input  logic [stg_pkg::FRAME_COUNT_BITS-1:0] frame_count,
	// result items
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [stg_pkg::SAMPLE_BITS-1:0] left_sample,
	output logic signed [stg_pkg::SAMPLE_BITS-1:0] right_sample,
	output logic                                 last_frame
);
	import stg_pkg::*;

	// configuration registers; amplitude is stored already clipped to 100
	logic [TUNING_BITS-1:0] tuning_q;
	logic [PCT_BITS-1:0]    pct_q;
	logic [PCT_BITS-1:0]    pct_wr;

	// oscillator state
	logic [PHASE_BITS-1:0]  phase_q;
	logic [COUNT_BITS-1:0]  frames_q;

	// stage 1: ROM read in flight
	logic                   v_s1;
	tag_t                   tag_s1;

	logic                   accept, issue, gain_ready;
	logic [1:0]             quad;
	logic [TABLE_ADDR_BITS-1:0] idx;
	logic [ROM_ADDR_BITS-1:0]   rom_addr;
	logic [MAG_BITS-1:0]        rom_data;
	logic signed [SAMPLE_BITS-1:0] sample;

	assign cfg_ready = 1'b1;
	assign pct_wr    = (cfg_data[PCT_BITS-1:0] > PCT_MAX) ? PCT_MAX : cfg_data[PCT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tuning_q <= '0;
			pct_q    <= PCT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_TUNING:    tuning_q <= cfg_data[TUNING_BITS-1:0];
				REG_AMPLITUDE: pct_q    <= pct_wr;
				default: ;
			endcase
		end
	end

	assign in_ready = ~v_s1 | gain_ready;
	assign accept   = in_valid & in_ready;
	// only a frame request with frames left makes a sample
	assign issue    = accept && (func == FUNC_FRAME) && (frames_q != '0);

	// quadrant picks table direction and sign; odd quadrants read mirrored
	assign quad     = phase_q[PHASE_BITS-1 -: 2];
	assign idx      = phase_q[PHASE_BITS-3 -: TABLE_ADDR_BITS];
	assign rom_addr = quad[0] ? (ROM_ADDR_BITS'(TABLE_N) - ROM_ADDR_BITS'(idx))
	                          : ROM_ADDR_BITS'(idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			frames_q <= '0;
			v_s1     <= 1'b0;
		end else begin
			if (accept && (func == FUNC_START)) begin
				frames_q <= COUNT_BITS'(frame_count);
				phase_q  <= '0;
			end else if (issue) begin
				// phase advances after the sample reads it
				frames_q <= frames_q - COUNT_BITS'(1);
				phase_q  <= phase_q + PHASE_BITS'(tuning_q);
			end
			if (in_ready) begin
				v_s1 <= issue;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			tag_s1.neg  <= quad[1];
			tag_s1.last <= (frames_q == COUNT_BITS'(1));
		end
	end

	stg_sine_rom u_rom (
		.clk  (clk),
		.en   (issue),
		.addr (rom_addr),
		.data (rom_data)
	);

	stg_gain_pipe u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (gain_ready),
		.mag       (rom_data),
		.tag       (tag_s1),
		.pct       (pct_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.last      (last_frame)
	);

	// mono sample on both channels
	assign left_sample  = sample;
	assign right_sample = sample;

endmodule
